>>> src/ltssd_pkg.sv
// ----------------------------------------------------------------------------
// ltssd_pkg
// shared types, codes and segment tables of the lap time display driver
// ----------------------------------------------------------------------------
package ltssd_pkg;

	typedef enum logic [2:0] {
		CMD_TICK_DIGITS  = 3'd0,
		CMD_TICK_LETTERS = 3'd1,
		CMD_LOAD_TIME    = 3'd2,
		CMD_LOAD_COUNT   = 3'd3,
		CMD_DASHES       = 3'd4,
		CMD_ZEROS        = 3'd5,
		CMD_LOAD_WORD    = 3'd6
	} cmd_t;

	// digit store codes: 0..9 digits, dash, everything else blank
	localparam logic [3:0] DASH_CODE  = 4'd10;
	localparam logic [3:0] BLANK_CODE = 4'd15;
	localparam logic [3:0] NINE_CODE  = 4'd9;

	// letter store codes: 0..25 are a..z
	localparam logic [4:0] LET_D = 5'd3;
	localparam logic [4:0] LET_E = 5'd4;
	localparam logic [4:0] LET_I = 5'd8;
	localparam logic [4:0] LET_M = 5'd12;
	localparam logic [4:0] LET_T = 5'd19;

	// last pipeline stage of the load arithmetic
	typedef struct packed {
		cmd_t        cmd;
		logic        min_zero;
		logic [3:0]  min_code;
		logic        count_big;
		logic        word_edit;
		logic        word_time;
		logic [2:0]  q10k;
		logic [5:0]  q1k;
		logic [9:0]  q100;
		logic [12:0] q10;
		logic [15:0] rest;
		logic [3:0]  c1k;
		logic [6:0]  c100;
		logic [9:0]  c10;
		logic [13:0] cnt;
	} item_t;

	// whole - 10 * tens, low four bits
	function automatic logic [3:0] low_digit(input logic [15:0] whole,
			input logic [15:0] tens);
		logic [15:0] diff;
		diff = whole - ((tens << 3) + (tens << 1));
		return diff[3:0];
	endfunction

	// bit 0 = a .. bit 6 = g, 1 lights the segment
	function automatic logic [6:0] digit_shape(input logic [3:0] code);
		logic [6:0] shape;
		unique case (code)
			4'd0:      shape = 7'h3F;
			4'd1:      shape = 7'h06;
			4'd2:      shape = 7'h5B;
			4'd3:      shape = 7'h4F;
			4'd4:      shape = 7'h66;
			4'd5:      shape = 7'h6D;
			4'd6:      shape = 7'h7D;
			4'd7:      shape = 7'h07;
			4'd8:      shape = 7'h7F;
			4'd9:      shape = 7'h6F;
			DASH_CODE: shape = 7'h40;
			default:   shape = 7'h00;
		endcase
		return shape;
	endfunction

	function automatic logic [6:0] letter_shape(input logic [4:0] code);
		logic [6:0] shape;
		unique case (code)
			5'd0:    shape = 7'h77;
			5'd1:    shape = 7'h7C;
			5'd2:    shape = 7'h39;
			5'd3:    shape = 7'h5E;
			5'd4:    shape = 7'h79;
			5'd5:    shape = 7'h71;
			5'd6:    shape = 7'h3D;
			5'd7:    shape = 7'h76;
			5'd8:    shape = 7'h06;
			5'd9:    shape = 7'h1E;
			5'd10:   shape = 7'h75;
			5'd11:   shape = 7'h38;
			5'd12:   shape = 7'h37;
			5'd13:   shape = 7'h54;
			5'd14:   shape = 7'h3F;
			5'd15:   shape = 7'h73;
			5'd16:   shape = 7'h67;
			5'd17:   shape = 7'h50;
			5'd18:   shape = 7'h6D;
			5'd19:   shape = 7'h78;
			5'd20:   shape = 7'h3E;
			5'd21:   shape = 7'h1C;
			5'd22:   shape = 7'h1D;
			5'd23:   shape = 7'h76;
			5'd24:   shape = 7'h6E;
			5'd25:   shape = 7'h5B;
			default: shape = 7'h00;
		endcase
		return shape;
	endfunction

endpackage

>>> src/ltssd_split.sv
// ----------------------------------------------------------------------------
// ltssd_split
// input register and constant-divisor pipeline that splits load values
// ----------------------------------------------------------------------------
module ltssd_split (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic [2:0]           command,
	input  logic [31:0]          value,
	input  logic                 commit_ready,
	output logic                 item_valid_s4,
	output ltssd_pkg::item_t     item_s4
);

	// x / 60000 = (x >> 5) / 1875, reciprocal exact for 27-bit operands
	localparam logic [27:0] MIN_RECIP = 28'(((64'd1 << 38) + 64'd1874) / 64'd1875);
	localparam logic [15:0] MS_PER_MIN = 16'd60000;
	localparam logic [31:0] COUNT_MAX  = 32'd9999;
	// reciprocals exact for 16-bit operands
	localparam logic [16:0] R10    = 17'(((64'd1 << 20) + 64'd9) / 64'd10);
	localparam logic [16:0] R100   = 17'(((64'd1 << 23) + 64'd99) / 64'd100);
	localparam logic [16:0] R1000  = 17'(((64'd1 << 26) + 64'd999) / 64'd1000);
	localparam logic [16:0] R10000 = 17'(((64'd1 << 30) + 64'd9999) / 64'd10000);

	logic              v_s1, v_s2, v_s3;
	logic              rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	ltssd_pkg::cmd_t   cmd_s1, cmd_s2, cmd_s3;
	logic [31:0]       value_s1, value_s2;
	logic [16:0]       minq_s2;
	logic [15:0]       rest_s3;
	logic [13:0]       cnt_s3;
	logic              min_zero_s3, count_big_s3, word_edit_s3, word_time_s3;
	logic [3:0]        min_code_s3;
	logic [54:0]       min_prod;
	logic [32:0]       min_back;
	logic [32:0]       p10, p100, p1000, p10000, pc10, pc100, pc1000;

	// bubble-collapsing ready chain
	assign rdy_s4     = !item_valid_s4 || commit_ready;
	assign rdy_s3     = !v_s3 || rdy_s4;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign item_ready = rdy_s1;

	assign min_prod = 55'(value_s1[31:5]) * 55'(MIN_RECIP);
	assign min_back = 33'(minq_s2) * 33'(MS_PER_MIN);
	assign p10      = 33'(rest_s3) * 33'(R10);
	assign p100     = 33'(rest_s3) * 33'(R100);
	assign p1000    = 33'(rest_s3) * 33'(R1000);
	assign p10000   = 33'(rest_s3) * 33'(R10000);
	assign pc10     = 33'(cnt_s3) * 33'(R10);
	assign pc100    = 33'(cnt_s3) * 33'(R100);
	assign pc1000   = 33'(cnt_s3) * 33'(R1000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			item_valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= item_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) item_valid_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && item_valid) begin
			cmd_s1   <= ltssd_pkg::cmd_t'(command);
			value_s1 <= value;
		end
		if (rdy_s2 && v_s1) begin
			cmd_s2   <= cmd_s1;
			value_s2 <= value_s1;
			minq_s2  <= min_prod[38 +: 17];
		end
		if (rdy_s3 && v_s2) begin
			cmd_s3       <= cmd_s2;
			rest_s3      <= value_s2[15:0] - min_back[15:0];
			min_zero_s3  <= (minq_s2 == '0);
			min_code_s3  <= (minq_s2 <= 17'(ltssd_pkg::NINE_CODE)) ? minq_s2[3:0]
				: ltssd_pkg::BLANK_CODE;
			count_big_s3 <= (value_s2 > COUNT_MAX);
			word_edit_s3 <= (value_s2 == 32'd0);
			word_time_s3 <= (value_s2 == 32'd1);
			cnt_s3       <= value_s2[13:0];
		end
		if (rdy_s4 && v_s3) begin
			item_s4.cmd       <= cmd_s3;
			item_s4.min_zero  <= min_zero_s3;
			item_s4.min_code  <= min_code_s3;
			item_s4.count_big <= count_big_s3;
			item_s4.word_edit <= word_edit_s3;
			item_s4.word_time <= word_time_s3;
			item_s4.q10k      <= p10000[30 +: 3];
			item_s4.q1k       <= p1000[26 +: 6];
			item_s4.q100      <= p100[23 +: 10];
			item_s4.q10       <= p10[20 +: 13];
			item_s4.rest      <= rest_s3;
			item_s4.c1k       <= pc1000[26 +: 4];
			item_s4.c100      <= pc100[23 +: 7];
			item_s4.c10       <= pc10[20 +: 10];
			item_s4.cnt       <= cnt_s3;
		end
	end

endmodule

>>> src/ltssd_display.sv
// ----------------------------------------------------------------------------
// ltssd_display
// digit and letter stores, scan position and registered pin outputs
// ----------------------------------------------------------------------------
module ltssd_display (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  ltssd_pkg::item_t     item,
	output logic                 commit_ready,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [6:0]           segment_pins,
	output logic                 dot_pin,
	output logic [3:0]           common_pins
);

	logic [3:0][3:0] digit_q, new_digits;
	logic [3:0]      dot_q, new_dots;
	logic [3:0][4:0] letter_q, new_letters;
	logic [1:0]      scan_q;
	logic            dig_we, dot_we, let_we;
	logic            is_tick, commit;
	logic [3:0]      sec_one, tenth, hund, thou;
	logic [3:0]      c_ones, c_tens, c_hund;
	logic [3:0]      tick_code;
	logic [6:0]      shape;
	logic            dot_lvl;
	logic [6:0]      seg_q;
	logic            dot_out_q;
	logic [3:0]      com_q;

	assign is_tick = (item.cmd == ltssd_pkg::CMD_TICK_DIGITS)
		|| (item.cmd == ltssd_pkg::CMD_TICK_LETTERS);
	assign commit_ready = !is_tick || !result_valid || result_ready;
	assign commit = item_valid && commit_ready;

	assign sec_one = ltssd_pkg::low_digit(16'(item.q1k), 16'(item.q10k));
	assign tenth   = ltssd_pkg::low_digit(16'(item.q100), 16'(item.q1k));
	assign hund    = ltssd_pkg::low_digit(16'(item.q10), 16'(item.q100));
	assign thou    = ltssd_pkg::low_digit(item.rest, 16'(item.q10));
	assign c_ones  = ltssd_pkg::low_digit(16'(item.cnt), 16'(item.c10));
	assign c_tens  = ltssd_pkg::low_digit(16'(item.c10), 16'(item.c100));
	assign c_hund  = ltssd_pkg::low_digit(16'(item.c100), 16'(item.c1k));

	// store updates for load commands
	always_comb begin
		dig_we      = 1'b0;
		dot_we      = 1'b0;
		let_we      = 1'b0;
		new_digits  = digit_q;
		new_dots    = dot_q;
		new_letters = letter_q;
		unique case (item.cmd)
			ltssd_pkg::CMD_LOAD_TIME: begin
				dig_we = 1'b1;
				dot_we = 1'b1;
				if (!item.min_zero) begin
					new_digits[0] = item.min_code;
					new_digits[1] = 4'(item.q10k);
					new_digits[2] = sec_one;
					new_digits[3] = tenth;
					new_dots      = 4'b0101;
				end else if (item.q1k != '0) begin
					new_digits[0] = 4'(item.q10k);
					new_digits[1] = sec_one;
					new_digits[2] = tenth;
					new_digits[3] = hund;
					new_dots      = 4'b0010;
				end else begin
					new_digits[0] = 4'd0;
					new_digits[1] = tenth;
					new_digits[2] = hund;
					new_digits[3] = thou;
					new_dots      = 4'b0001;
				end
			end
			ltssd_pkg::CMD_LOAD_COUNT: begin
				dig_we = 1'b1;
				if (item.count_big) begin
					new_digits = {4{ltssd_pkg::BLANK_CODE}};
				end else begin
					// leading blanks above the highest nonzero digit
					new_digits[3] = c_ones;
					new_digits[2] = (item.c10 != '0) ? c_tens : ltssd_pkg::BLANK_CODE;
					new_digits[1] = (item.c100 != '0) ? c_hund : ltssd_pkg::BLANK_CODE;
					new_digits[0] = (item.c1k != '0) ? item.c1k : ltssd_pkg::BLANK_CODE;
				end
			end
			ltssd_pkg::CMD_DASHES: begin
				dig_we     = 1'b1;
				new_digits = {4{ltssd_pkg::DASH_CODE}};
			end
			ltssd_pkg::CMD_ZEROS: begin
				dig_we     = 1'b1;
				new_digits = '0;
			end
			ltssd_pkg::CMD_LOAD_WORD: begin
				if (item.word_edit) begin
					let_we         = 1'b1;
					new_letters[0] = ltssd_pkg::LET_E;
					new_letters[1] = ltssd_pkg::LET_D;
					new_letters[2] = ltssd_pkg::LET_I;
					new_letters[3] = ltssd_pkg::LET_T;
				end else if (item.word_time) begin
					let_we         = 1'b1;
					new_letters[0] = ltssd_pkg::LET_T;
					new_letters[1] = ltssd_pkg::LET_I;
					new_letters[2] = ltssd_pkg::LET_M;
					new_letters[3] = ltssd_pkg::LET_E;
				end
			end
			default: ;
		endcase
	end

	// scanned position lookup
	assign tick_code = digit_q[scan_q];
	always_comb begin
		if (item.cmd == ltssd_pkg::CMD_TICK_LETTERS) begin
			shape   = ltssd_pkg::letter_shape(letter_q[scan_q]);
			dot_lvl = 1'b1;
		end else begin
			shape   = ltssd_pkg::digit_shape(tick_code);
			dot_lvl = (tick_code <= ltssd_pkg::NINE_CODE) ? !dot_q[scan_q] : 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q      <= '0;
			dot_q        <= '0;
			letter_q[0]  <= ltssd_pkg::LET_E;
			letter_q[1]  <= ltssd_pkg::LET_D;
			letter_q[2]  <= ltssd_pkg::LET_I;
			letter_q[3]  <= ltssd_pkg::LET_T;
			scan_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			if (commit && dig_we) digit_q <= new_digits;
			if (commit && dot_we) dot_q <= new_dots;
			if (commit && let_we) letter_q <= new_letters;
			if (commit && is_tick) begin
				scan_q       <= scan_q + 2'd1;
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit && is_tick) begin
			seg_q     <= ~shape;
			dot_out_q <= dot_lvl;
			com_q     <= ~(4'b0001 << scan_q);
		end
	end

	assign segment_pins = seg_q;
	assign dot_pin      = dot_out_q;
	assign common_pins  = com_q;

endmodule

>>> src/lap_time_seven_segment_driver.sv
// ----------------------------------------------------------------------------
// lap_time_seven_segment_driver
// four-digit multiplexed seven-segment driver with lap time and count loads
// ----------------------------------------------------------------------------
//
//   channel  handshake                   payload
//   -------  --------------------------  ------------------------------------
//   item     item_valid / item_ready     command[2:0], value[31:0]
//   result   result_valid / result_ready segment_pins[6:0], dot_pin,
//                                        common_pins[3:0]
//
// one word accepted per cycle while item_ready is high; a tick word passes an
// input register and three stages of constant-divisor multipliers ahead of
// the display stores (ticks ride the same stages to keep order with loads)
// load words give no result word and only update the stores
// arst_n clears the pipeline, the stores to zeros and "edit", and scan to 0
// a tick held at the last stage waits only while the result word is not
// taken; empty stages ahead of it keep filling

module lap_time_seven_segment_driver (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  command,
	input  logic [31:0] value,
	// result channel
	output logic        result_valid,
	input  logic        result_ready,
	output logic [6:0]  segment_pins,
	output logic        dot_pin,
	output logic [3:0]  common_pins
);

	// last arithmetic stage handed to the display stores
	logic             item_valid_s4;
	ltssd_pkg::item_t item_s4;
	// display side can take the staged word
	logic             commit_ready;

	// splits milliseconds into minutes, seconds and fractions, and counts
	// into decimal digits, all by reciprocal multiplication
	ltssd_split u_split (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.command       (command),
		.value         (value),
		.commit_ready  (commit_ready),
		.item_valid_s4 (item_valid_s4),
		.item_s4       (item_s4)
	);

	// stores, scan counter and registered active-low pins
	ltssd_display u_display (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid_s4),
		.item         (item_s4),
		.commit_ready (commit_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.segment_pins (segment_pins),
		.dot_pin      (dot_pin),
		.common_pins  (common_pins)
	);

endmodule

>>> src/ltssd_checker.sv
// ----------------------------------------------------------------------------
// ltssd_checker
// port-level checks of the display driver, bound to the top level
// ----------------------------------------------------------------------------
module ltssd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic [6:0] segment_pins,
	input logic       dot_pin,
	input logic [3:0] common_pins
);

	// a waiting result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(segment_pins)
			&& $stable(dot_pin) && $stable(common_pins))
		else $error("result word changed while stalled");

	// exactly one common driven low
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot(~common_pins))
		else $error("common pins not one-hot");

	// a lit dot only comes with a digit shape
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !dot_pin |-> segment_pins != 7'h7F)
		else $error("dot lit on a blank position");

	// consecutive results step the scan by one position
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_ready) ##1 result_valid |->
			common_pins == {$past(common_pins[2:0]), $past(common_pins[3])})
		else $error("scan position skipped");

endmodule

bind lap_time_seven_segment_driver ltssd_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.segment_pins (segment_pins),
	.dot_pin      (dot_pin),
	.common_pins  (common_pins)
);

>>> tb/lap_time_seven_segment_driver_tb.sv
// ----------------------------------------------------------------------------
// lap_time_seven_segment_driver_tb
// self-checking bench for the lap time seven-segment display driver
//
// A short table of hand-picked words goes first: reset state, the extremes of
// the time and count loads, dashes, zeros, both words, an unknown word select
// and the unused command. Then random words follow, about half of them ticks.
// A local display model predicts every tick word and the receiver compares
// each result word with the oldest prediction. Both channels idle at random,
// with some stretches that run at full rate.
// ----------------------------------------------------------------------------
module lap_time_seven_segment_driver_tb;

	timeunit 1ns;
	timeprecision 1ps;

	// the one command code that the package leaves unnamed, ignored by the block
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	localparam int unsigned RANDOM_WORDS = 1800;
	localparam int unsigned MAX_IDLE     = 14;

	// lit-segment patterns, entry k in bits [7k +: 7], bit 0 = a .. bit 6 = g
	localparam logic [69:0] DIGIT_GLYPHS = {
		7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
	};
	localparam logic [181:0] LETTER_GLYPHS = {
		7'h5B, 7'h6E, 7'h76, 7'h1D, 7'h1C, 7'h3E, 7'h78, 7'h6D, 7'h50,
		7'h67, 7'h73, 7'h3F, 7'h54, 7'h37, 7'h38, 7'h75, 7'h1E, 7'h06,
		7'h76, 7'h3D, 7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77
	};
	localparam logic [6:0] DASH_GLYPH = 7'h40;

	// one result word as seen on the pins
	typedef struct packed {
		logic [6:0] seg;
		logic       dot;
		logic [3:0] com;
	} frame_t;

	// one row of the directed table
	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] val;
		logic        fixed;
		frame_t      frame;
	} stim_row_t;

	localparam frame_t NO_FRAME = '{7'h00, 1'b0, 4'h0};

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_ready;
	logic [2:0]  command      = 3'd0;
	logic [31:0] value        = 32'd0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [6:0]  segment_pins;
	logic        dot_pin;
	logic [3:0]  common_pins;

	// local copy of the display stores
	logic [3:0] digit_store  [4];
	logic       dot_store    [4];
	logic [4:0] letter_store [4];
	logic [1:0] scan_pos;

	frame_t    pending_frames [$];
	stim_row_t dir_rows [26];
	int        errors   = 0;
	bit        tx_burst = 1'b0;
	bit        rx_burst = 1'b0;

	lap_time_seven_segment_driver u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.command      (command),
		.value        (value),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.segment_pins (segment_pins),
		.dot_pin      (dot_pin),
		.common_pins  (common_pins)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// updates the local stores for one word; returns 1 with the frame for a tick
	function automatic bit predict_display(input logic [2:0] cmd, input logic [31:0] val,
			output frame_t frame);
		int unsigned minutes, rest, seconds, tenths, hund, thou, n;
		int          i;
		logic [6:0]  shape;
		logic        dp;
		logic [3:0]  code;
		logic [4:0]  lcode;
		frame = NO_FRAME;
		shape = 7'h00;
		dp    = 1'b1;
		case (cmd)
			ltssd_pkg::CMD_TICK_DIGITS: begin
				code = digit_store[scan_pos];
				if (code <= ltssd_pkg::NINE_CODE) begin
					shape = DIGIT_GLYPHS[code * 7 +: 7];
					// dot lights only on a real digit with its flag set
					dp    = ~dot_store[scan_pos];
				end else if (code == ltssd_pkg::DASH_CODE) begin
					shape = DASH_GLYPH;
				end
			end
			ltssd_pkg::CMD_TICK_LETTERS: begin
				// letters never light the dot
				lcode = letter_store[scan_pos];
				if (lcode < 5'd26)
					shape = LETTER_GLYPHS[lcode * 7 +: 7];
			end
			ltssd_pkg::CMD_LOAD_TIME: begin
				minutes = val / 60000;
				rest    = val % 60000;
				seconds = rest / 1000;
				rest    = rest % 1000;
				tenths  = rest / 100;
				hund    = (rest % 100) / 10;
				thou    = rest % 10;
				if (minutes != 0) begin
					// M.SS.t, minutes past nine show blank but keep the flag
					digit_store[0] = (minutes <= 9) ? minutes[3:0] : ltssd_pkg::BLANK_CODE;
					digit_store[1] = 4'(seconds / 10);
					digit_store[2] = 4'(seconds % 10);
					digit_store[3] = 4'(tenths);
					dot_store[0] = 1'b1;
					dot_store[1] = 1'b0;
					dot_store[2] = 1'b1;
					dot_store[3] = 1'b0;
				end else if (seconds != 0) begin
					// SS.th
					digit_store[0] = 4'(seconds / 10);
					digit_store[1] = 4'(seconds % 10);
					digit_store[2] = 4'(tenths);
					digit_store[3] = 4'(hund);
					dot_store[0] = 1'b0;
					dot_store[1] = 1'b1;
					dot_store[2] = 1'b0;
					dot_store[3] = 1'b0;
				end else begin
					// 0.thm
					digit_store[0] = 4'd0;
					digit_store[1] = 4'(tenths);
					digit_store[2] = 4'(hund);
					digit_store[3] = 4'(thou);
					dot_store[0] = 1'b1;
					dot_store[1] = 1'b0;
					dot_store[2] = 1'b0;
					dot_store[3] = 1'b0;
				end
			end
			ltssd_pkg::CMD_LOAD_COUNT: begin
				// right-aligned, leading blanks, all blank past four digits
				n = val;
				for (i = 3; i >= 0; i--) begin
					if (val > 9999) begin
						digit_store[i] = ltssd_pkg::BLANK_CODE;
					end else if (i == 3 || n != 0) begin
						digit_store[i] = 4'(n % 10);
						n = n / 10;
					end else begin
						digit_store[i] = ltssd_pkg::BLANK_CODE;
					end
				end
			end
			ltssd_pkg::CMD_DASHES: begin
				for (i = 0; i < 4; i++)
					digit_store[i] = ltssd_pkg::DASH_CODE;
			end
			ltssd_pkg::CMD_ZEROS: begin
				for (i = 0; i < 4; i++)
					digit_store[i] = 4'd0;
			end
			ltssd_pkg::CMD_LOAD_WORD: begin
				// any other select leaves the letters alone
				if (val == 32'd0) begin
					letter_store[0] = ltssd_pkg::LET_E;
					letter_store[1] = ltssd_pkg::LET_D;
					letter_store[2] = ltssd_pkg::LET_I;
					letter_store[3] = ltssd_pkg::LET_T;
				end else if (val == 32'd1) begin
					letter_store[0] = ltssd_pkg::LET_T;
					letter_store[1] = ltssd_pkg::LET_I;
					letter_store[2] = ltssd_pkg::LET_M;
					letter_store[3] = ltssd_pkg::LET_E;
				end
			end
			default: ;
		endcase
		if (cmd == ltssd_pkg::CMD_TICK_DIGITS || cmd == ltssd_pkg::CMD_TICK_LETTERS) begin
			frame.seg = ~shape;
			frame.dot = dp;
			frame.com = ~(4'b0001 << scan_pos);
			scan_pos  = scan_pos + 2'd1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// drives one word, waits for it to be taken, then records the prediction;
	// entered at the edge that took the previous word so valid can stay high
	task automatic send_word(input logic [2:0] cmd, input logic [31:0] val,
			input logic fixed, input frame_t fixed_frame);
		int unsigned gap;
		frame_t      frame;
		gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		command    <= cmd;
		value      <= val;
		do @(posedge clk); while (!item_ready);
		if (predict_display(cmd, val, frame))
			pending_frames.push_back(fixed ? fixed_frame : frame);
	endtask

	// receiver: random stall before each word, compare on acceptance
	int unsigned rx_wait = 0;
	int unsigned rx_draw;
	frame_t      rx_want;
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			rx_wait      <= 0;
		end else if (result_ready && result_valid) begin
			if (pending_frames.size() == 0) begin
				$display("%0t: result word with none predicted: seg %h dot %b com %h",
					$time, segment_pins, dot_pin, common_pins);
				errors++;
			end else begin
				rx_want = pending_frames.pop_front();
				if (segment_pins !== rx_want.seg) begin
					$display("%0t: segment_pins expected %h got %h",
						$time, rx_want.seg, segment_pins);
					errors++;
				end
				if (dot_pin !== rx_want.dot) begin
					$display("%0t: dot_pin expected %b got %b", $time, rx_want.dot, dot_pin);
					errors++;
				end
				if (common_pins !== rx_want.com) begin
					$display("%0t: common_pins expected %h got %h",
						$time, rx_want.com, common_pins);
					errors++;
				end
			end
			rx_draw = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
			if (rx_draw != 0) begin
				result_ready <= 1'b0;
				rx_wait      <= rx_draw - 1;
			end
		end else if (!result_ready) begin
			if (rx_wait == 0)
				result_ready <= 1'b1;
			else
				rx_wait <= rx_wait - 1;
		end
	end

	initial begin
		int          i;
		int unsigned pick, sub;
		logic [2:0]  cmd;
		logic [31:0] val;

		// directed words; typed frames only where the answer is obvious
		dir_rows = '{
			// reset state: digit zero, then d i t of "edit" read back at positions 1..3
			'{ltssd_pkg::CMD_TICK_DIGITS,  32'd0,         1'b1, '{7'h40, 1'b1, 4'hE}},
			'{ltssd_pkg::CMD_TICK_LETTERS, 32'd0,         1'b1, '{7'h21, 1'b1, 4'hD}},
			'{ltssd_pkg::CMD_TICK_LETTERS, 32'd0,         1'b1, '{7'h79, 1'b1, 4'hB}},
			'{ltssd_pkg::CMD_TICK_LETTERS, 32'd0,         1'b1, '{7'h07, 1'b1, 4'h7}},
			// dash
			'{ltssd_pkg::CMD_DASHES,       32'd0,         1'b0, NO_FRAME},
			'{ltssd_pkg::CMD_TICK_DIGITS,  32'd0,         1'b1, '{7'h3F, 1'b1, 4'hE}},
			// counts past four digits go blank
			'{ltssd_pkg::CMD_LOAD_COUNT,   32'd10000,     1'b0, NO_FRAME},
			'{ltssd_pkg::CMD_TICK_DIGITS,  32'd0,         1'b1, '{7'h7F, 1'b1, 4'hD}},
			'{ltssd_pkg::CMD_LOAD_COUNT,   32'hFFFF_FFFF, 1'b0, NO_FRAME},
			'{ltssd_pkg::CMD_TICK_DIGITS,  32'd0,         1'b1, '{7'h7F, 1'b1, 4'hB}},
			// time extremes: zero, huge minutes, 9:59.9, 59.99, then count 9999 and zeros
			'{ltssd_pkg::CMD_LOAD_TIME,    32'd0,         1'b0, NO_FRAME},
			'{ltssd_pkg::CMD_TICK_DIGITS,  32'd0,         1'b0, NO_FRAME},
			'{ltssd_pkg::CMD_LOAD_TIME,    32'hFFFF_FFFF, 1'b0, NO_FRAME},
			'{ltssd_pkg::CMD_TICK_DIGITS,  32'd0,         1'b0, NO_FRAME},
			'{ltssd_pkg::CMD_LOAD_TIME,    32'd599999,    1'b0, NO_FRAME},
			'{ltssd_pkg::CMD_TICK_DIGITS,  32'd0,         1'b0, NO_FRAME},
			'{ltssd_pkg::CMD_LOAD_TIME,    32'd59999,     1'b0, NO_FRAME},
			'{ltssd_pkg::CMD_TICK_DIGITS,  32'd0,         1'b0, NO_FRAME},
			'{ltssd_pkg::CMD_LOAD_COUNT,   32'd9999,      1'b0, NO_FRAME},
			'{ltssd_pkg::CMD_TICK_DIGITS,  32'd0,         1'b0, NO_FRAME},
			'{ltssd_pkg::CMD_ZEROS,        32'd0,         1'b0, NO_FRAME},
			// words, an unknown select and the unused command
			'{ltssd_pkg::CMD_LOAD_WORD,    32'd1,         1'b0, NO_FRAME},
			'{ltssd_pkg::CMD_TICK_LETTERS, 32'd0,         1'b0, NO_FRAME},
			'{ltssd_pkg::CMD_LOAD_WORD,    32'd2,         1'b0, NO_FRAME},
			'{CMD_UNUSED,                  32'hFFFF_FFFF, 1'b0, NO_FRAME},
			'{ltssd_pkg::CMD_TICK_LETTERS, 32'd0,         1'b0, NO_FRAME}
		};

		// model state after reset
		for (i = 0; i < 4; i++) begin
			digit_store[i] = 4'd0;
			dot_store[i]   = 1'b0;
		end
		letter_store[0] = ltssd_pkg::LET_E;
		letter_store[1] = ltssd_pkg::LET_D;
		letter_store[2] = ltssd_pkg::LET_I;
		letter_store[3] = ltssd_pkg::LET_T;
		scan_pos = 2'd0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k])
			send_word(dir_rows[k].cmd, dir_rows[k].val, dir_rows[k].fixed, dir_rows[k].frame);

		// hold off until the directed results have drained
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_frames.size() != 0) @(posedge clk);

		for (i = 0; i < RANDOM_WORDS; i++) begin
			// switch between idling and full-rate stretches
			if (i % 150 == 0) begin
				tx_burst = ($urandom_range(0, 3) == 0);
				rx_burst = ($urandom_range(0, 3) == 0);
			end
			// drain once in the middle of the random run
			if (i == RANDOM_WORDS / 2) begin
				item_valid <= 1'b0;
				@(posedge clk);
				while (pending_frames.size() != 0) @(posedge clk);
			end
			pick = $urandom_range(0, 99);
			sub  = $urandom_range(0, 5);
			val  = $urandom();
			if (pick < 30) begin
				cmd = ltssd_pkg::CMD_TICK_DIGITS;
			end else if (pick < 50) begin
				cmd = ltssd_pkg::CMD_TICK_LETTERS;
			end else if (pick < 62) begin
				// spread over the three display formats and beyond
				cmd = ltssd_pkg::CMD_LOAD_TIME;
				case (sub)
					0:       val = $urandom_range(0, 999);
					1:       val = $urandom_range(1000, 59999);
					2, 3:    val = $urandom_range(60000, 599999);
					4:       val = $urandom_range(600000, 6000000);
					default: ;
				endcase
			end else if (pick < 72) begin
				cmd = ltssd_pkg::CMD_LOAD_COUNT;
				case (sub)
					0:       val = $urandom_range(0, 9);
					1:       val = $urandom_range(10, 99);
					2:       val = $urandom_range(100, 999);
					3:       val = $urandom_range(1000, 9999);
					4:       val = $urandom_range(9999, 10000);
					default: ;
				endcase
			end else if (pick < 78) begin
				cmd = ltssd_pkg::CMD_DASHES;
			end else if (pick < 84) begin
				cmd = ltssd_pkg::CMD_ZEROS;
			end else if (pick < 96) begin
				cmd = ltssd_pkg::CMD_LOAD_WORD;
				if (sub < 5)
					val = {31'd0, sub[0]};
			end else begin
				cmd = CMD_UNUSED;
			end
			send_word(cmd, val, 1'b0, NO_FRAME);
		end

		item_valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		// keep running for any stray result word
		repeat (20) @(posedge clk);
		if (pending_frames.size() != 0) begin
			$display("%0t: %0d predicted result words never arrived",
				$time, pending_frames.size());
			errors++;
		end
		if (errors == 0)
			$display("[lap_time_seven_segment_driver] OK");
		else
			$display("[lap_time_seven_segment_driver] ERROR");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("[lap_time_seven_segment_driver] ERROR");
		$finish;
	end

endmodule
